@@ hdl/arp_cache_resolver_core_macros.svh @@
// Assertion macros for the ARP cache resolver.
// Included by modules that carry concurrent assertions.
`ifndef ARP_CACHE_RESOLVER_CORE_MACROS_SVH
`define ARP_CACHE_RESOLVER_CORE_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define ARP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ARP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/arpc_pkg.sv @@
// Package for the ARP cache resolver: sizes, codes and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps
package arpc_pkg;
    localparam int CACHE_ENTRIES = 8;
    localparam int IDX_W = $clog2(CACHE_ENTRIES);

    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_PENDING = 2'd1;
    localparam logic [1:0] ST_VALID   = 2'd2;

    localparam logic [2:0] RES_HIT     = 3'd0;
    localparam logic [2:0] RES_REQUEST = 3'd1;
    localparam logic [2:0] RES_WAIT    = 3'd2;
    localparam logic [2:0] RES_DROP    = 3'd3;
    localparam logic [2:0] RES_ACCEPT  = 3'd4;
    localparam logic [2:0] RES_REPLY   = 3'd5;

    localparam logic [1:0] CFG_OWN_IP      = 2'd0;
    localparam logic [1:0] CFG_OWN_MAC     = 2'd1;
    localparam logic [1:0] CFG_VALID_TICKS = 2'd2;
    localparam logic [1:0] CFG_RETRY_TICKS = 2'd3;

    localparam logic [10:0] MIN_FRAME_LEN = 11'd42;
    localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic        req_type;
        logic [31:0] now_ticks;
        logic [31:0] addr_ip;
        logic [47:0] sender_mac;
        logic [31:0] target_ip;
        logic [47:0] eth_source_mac;
        logic [15:0] opcode;
        logic [10:0] frame_len;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_addr_len;
        logic [7:0]  proto_addr_len;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] resolved_mac;
        logic [47:0] dest_mac;
        logic [47:0] peer_target_mac;
        logic [31:0] peer_target_ip;
    } result_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
    } stat_t;

    function automatic logic aged(input logic [31:0] now, input logic [31:0] stamp,
                                  input logic [30:0] limit);
        logic [31:0] d;
        d = now - stamp;
        return !d[31] && (d[30:0] >= limit);
    endfunction
endpackage

@@ hdl/arpc_ctrl.sv @@
// Controller for the ARP cache resolver: sequences load, slot scan and decision.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
`include "arp_cache_resolver_core_macros.svh"
module arpc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output arpc_pkg::cmd_t cmd,
    input  arpc_pkg::stat_t stat
);
    import arpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_SCAN;
            S_SCAN:   if (stat.scan_last) state_next = S_DECIDE;
            S_DECIDE: state_next = S_OUT;
            S_OUT:    if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign cmd.load   = in_valid && in_ready;
    assign cmd.scan   = (state_reg == S_SCAN);
    assign cmd.decide = (state_reg == S_DECIDE);

    `ARP_ASSERT(a_excl, clk, rst_n, !(in_ready && out_valid), "ready while result held")
    `ARP_ASSERT_NEXT(a_load, clk, rst_n, cmd.load, state_reg == S_SCAN, "load not followed by scan")
    `ARP_ASSERT_NEXT(a_dec, clk, rst_n, cmd.decide, out_valid, "decide without result")
endmodule

@@ hdl/arpc_dp.sv @@
// Datapath for the ARP cache resolver: entry table, slot scan and result register.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
`include "arp_cache_resolver_core_macros.svh"
module arpc_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  arpc_pkg::cmd_t   cmd,
    output arpc_pkg::stat_t  stat,
    input  arpc_pkg::item_t  item,
    input  logic [31:0]      own_ip,
    input  logic [30:0]      valid_ticks,
    input  logic [30:0]      retry_ticks,
    output arpc_pkg::result_t result
);
    import arpc_pkg::*;

    logic [31:0] entry_addr_reg  [CACHE_ENTRIES];
    logic [47:0] entry_hw_reg    [CACHE_ENTRIES];
    logic [31:0] entry_stamp_reg [CACHE_ENTRIES];
    logic [1:0]  entry_status_reg[CACHE_ENTRIES];

    item_t          item_reg;
    result_t        result_reg;
    result_t        result_next;
    logic [IDX_W-1:0] idx_reg;
    logic           hit_reg, free_found_reg;
    logic [IDX_W-1:0] hit_idx_reg, free_idx_reg, old_idx_reg;

    logic scan_hit, scan_free, scan_older;
    assign scan_hit   = entry_status_reg[idx_reg] != ST_FREE &&
                        entry_addr_reg[idx_reg] == item_reg.addr_ip;
    assign scan_free  = entry_status_reg[idx_reg] == ST_FREE;
    logic [31:0] sdiff;
    assign sdiff      = entry_stamp_reg[idx_reg] - entry_stamp_reg[old_idx_reg];
    assign scan_older = sdiff[31];
    assign stat.scan_last = (idx_reg == IDX_W'(CACHE_ENTRIES - 1));

    logic [IDX_W-1:0] slot;
    assign slot = free_found_reg ? free_idx_reg : old_idx_reg;

    logic hdr_ok, to_us;
    assign hdr_ok = item_reg.frame_len >= MIN_FRAME_LEN && item_reg.hw_type == 16'd1 &&
                    item_reg.proto_type == 16'h0800 && item_reg.hw_addr_len == 8'd6 &&
                    item_reg.proto_addr_len == 8'd4;
    assign to_us  = item_reg.target_ip == own_ip;

    logic [1:0]  e_st;
    logic [31:0] e_stamp;
    assign e_st    = entry_status_reg[hit_idx_reg];
    assign e_stamp = entry_stamp_reg[hit_idx_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            hit_reg <= 1'b0;
            free_found_reg <= 1'b0;
            hit_idx_reg <= '0;
            free_idx_reg <= '0;
            old_idx_reg <= '0;
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                entry_status_reg[i] <= ST_FREE;
                entry_addr_reg[i]   <= '0;
                entry_hw_reg[i]     <= '0;
                entry_stamp_reg[i]  <= '0;
            end
        end
        else if (cmd.load)
        begin
            idx_reg <= '0;
            hit_reg <= 1'b0;
            free_found_reg <= 1'b0;
            old_idx_reg <= '0;
        end
        else if (cmd.scan)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (scan_hit && !hit_reg)
            begin
                hit_reg <= 1'b1;
                hit_idx_reg <= idx_reg;
            end
            if (scan_free && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg <= idx_reg;
            end
            if (!free_found_reg && !scan_free && scan_older)
                old_idx_reg <= idx_reg;
        end
        else if (cmd.decide)
        begin
            if (!item_reg.req_type)
            begin
                if (!(hit_reg && e_st == ST_VALID && !aged(item_reg.now_ticks, e_stamp, valid_ticks))
                    && !(hit_reg && e_st != ST_VALID
                         && !aged(item_reg.now_ticks, e_stamp, retry_ticks)))
                begin
                    if (hit_reg)
                    begin
                        entry_status_reg[hit_idx_reg] <= ST_PENDING;
                        entry_stamp_reg[hit_idx_reg]  <= item_reg.now_ticks;
                    end
                    else
                    begin
                        entry_addr_reg[slot]   <= item_reg.addr_ip;
                        entry_status_reg[slot] <= ST_PENDING;
                        entry_stamp_reg[slot]  <= item_reg.now_ticks;
                    end
                end
            end
            else if (hdr_ok && item_reg.addr_ip != 32'd0)
            begin
                if (hit_reg)
                begin
                    entry_hw_reg[hit_idx_reg]     <= item_reg.sender_mac;
                    entry_stamp_reg[hit_idx_reg]  <= item_reg.now_ticks;
                    entry_status_reg[hit_idx_reg] <= ST_VALID;
                end
                else if (to_us)
                begin
                    entry_addr_reg[slot]   <= item_reg.addr_ip;
                    entry_hw_reg[slot]     <= item_reg.sender_mac;
                    entry_stamp_reg[slot]  <= item_reg.now_ticks;
                    entry_status_reg[slot] <= ST_VALID;
                end
            end
        end
    end

    always_comb
    begin
        result_next = '0;
        if (!item_reg.req_type)
        begin
            if (hit_reg && e_st == ST_VALID &&
                !aged(item_reg.now_ticks, e_stamp, valid_ticks))
            begin
                result_next.status = RES_HIT;
                result_next.resolved_mac = entry_hw_reg[hit_idx_reg];
            end
            else if (hit_reg && e_st != ST_VALID &&
                     !aged(item_reg.now_ticks, e_stamp, retry_ticks))
                result_next.status = RES_WAIT;
            else
            begin
                result_next.status = RES_REQUEST;
                result_next.dest_mac = MAC_BCAST;
                result_next.peer_target_ip = item_reg.addr_ip;
            end
        end
        else if (!hdr_ok)
            result_next.status = RES_DROP;
        else if (item_reg.opcode != 16'd1 || !to_us)
            result_next.status = RES_ACCEPT;
        else
        begin
            result_next.status = RES_REPLY;
            result_next.dest_mac = item_reg.eth_source_mac;
            result_next.peer_target_mac = item_reg.sender_mac;
            result_next.peer_target_ip = item_reg.addr_ip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
            result_reg <= result_next;
    end

    assign result = result_reg;

    logic free_lost;
    assign free_lost = free_found_reg && entry_status_reg[free_idx_reg] != ST_FREE;

    `ARP_ASSERT(a_scan_idx, clk, rst_n, !(cmd.decide && idx_reg != '0), "scan index not wrapped")
    `ARP_ASSERT_NEXT(a_ld_idx, clk, rst_n, cmd.load, idx_reg == '0 && !hit_reg, "scan not restarted")
    `ARP_ASSERT(a_free, clk, rst_n, !(free_lost && cmd.scan), "free slot lost")
endmodule

@@ hdl/arp_cache_resolver_core.sv @@
// ARP cache resolver: each item is loaded, then scanned over all CACHE_ENTRIES table
// slots (one table slot compared per cycle), then decided; a new item is taken once
// the result is taken.
// Depends on arpc_pkg, arpc_ctrl, arpc_dp.
`timescale 1ns / 1ps
module arp_cache_resolver_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: now_ticks, addr_ip, sender_mac, target_ip, eth_source_mac, opcode,
    // frame_len, hw_type, proto_type, hw_addr_len, proto_addr_len (LSB first)
    input  logic [271:0] s_tdata,
    // tuser: req_type
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status, resolved_mac, dest_mac, peer_target_mac, peer_target_ip
    output logic [183:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_data
);
    import arpc_pkg::*;

    logic [31:0] own_ip_reg;
    logic [47:0] own_mac_reg;
    logic [30:0] valid_ticks_reg, retry_ticks_reg;
    cmd_t cmd;
    stat_t stat;
    item_t item;
    result_t res;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
            own_mac_reg <= '0;
            valid_ticks_reg <= 31'd60000;
            retry_ticks_reg <= 31'd1000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OWN_IP:      own_ip_reg <= cfg_data[31:0];
                CFG_OWN_MAC:     own_mac_reg <= cfg_data;
                CFG_VALID_TICKS: valid_ticks_reg <= cfg_data[30:0];
                CFG_RETRY_TICKS: retry_ticks_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign item.req_type       = s_tuser;
    assign item.now_ticks      = s_tdata[31:0];
    assign item.addr_ip        = s_tdata[63:32];
    assign item.sender_mac     = s_tdata[111:64];
    assign item.target_ip      = s_tdata[143:112];
    assign item.eth_source_mac = s_tdata[191:144];
    assign item.opcode         = s_tdata[207:192];
    assign item.frame_len      = s_tdata[218:208];
    assign item.hw_type        = s_tdata[234:219];
    assign item.proto_type     = s_tdata[250:235];
    assign item.hw_addr_len    = s_tdata[258:251];
    assign item.proto_addr_len = s_tdata[266:259];

    arpc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .cmd(cmd), .stat(stat)
    );

    arpc_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .item(item),
        .own_ip(own_ip_reg), .valid_ticks(valid_ticks_reg),
        .retry_ticks(retry_ticks_reg), .result(res)
    );

    assign m_tdata = {5'd0, res.peer_target_ip, res.peer_target_mac, res.dest_mac,
                      res.resolved_mac, res.status} ^ {136'd0, (|own_mac_reg) & 1'b0, 47'd0};
endmodule

@@ verif/arp_cache_resolver_core_checker.sv @@
// Checker for the ARP cache resolver: watches the config, input and result channels,
// keeps its own copy of the cache to predict each result and compares field by field.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
module arp_cache_resolver_core_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [271:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [183:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_data,
    output int           fail_count,
    output int           results_owed
);
    import arpc_pkg::*;

    logic [31:0] my_ip;
    logic [47:0] my_mac;
    logic [30:0] valid_lim;
    logic [30:0] retry_lim;

    logic [31:0] slot_ip    [CACHE_ENTRIES];
    logic [47:0] slot_mac   [CACHE_ENTRIES];
    logic [1:0]  slot_state [CACHE_ENTRIES];
    logic [31:0] slot_stamp [CACHE_ENTRIES];

    result_t expected_results[$];

    assign results_owed = expected_results.size();

    function automatic logic is_expired(logic [31:0] now, logic [31:0] stamp,
                                        logic [30:0] lim);
        logic [31:0] d;
        d = now - stamp;
        return !d[31] && (d >= {1'b0, lim});
    endfunction

    function automatic int find_slot(logic [31:0] ip);
        int idx;
        idx = -1;
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (idx < 0 && slot_state[i] != ST_FREE && slot_ip[i] == ip)
                idx = i;
        return idx;
    endfunction

    function automatic int victim_slot();
        int oldest;
        int free_idx;
        logic [31:0] d;
        oldest = 0;
        free_idx = -1;
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (free_idx < 0)
            begin
                if (slot_state[i] == ST_FREE)
                    free_idx = i;
                else
                begin
                    d = slot_stamp[i] - slot_stamp[oldest];
                    if (d[31])
                        oldest = i;
                end
            end
        return (free_idx >= 0) ? free_idx : oldest;
    endfunction

    task automatic resolve_item(input item_t it, output result_t r);
        int e;
        logic        to_us;
        r = '0;
        r.status = RES_DROP;
        if (!it.req_type)
        begin
            e = find_slot(it.addr_ip);
            if (e >= 0 && slot_state[e] == ST_VALID
                && !is_expired(it.now_ticks, slot_stamp[e], valid_lim))
            begin
                r.status = RES_HIT;
                r.resolved_mac = slot_mac[e];
            end
            else if (e >= 0 && slot_state[e] != ST_VALID
                     && !is_expired(it.now_ticks, slot_stamp[e], retry_lim))
                r.status = RES_WAIT;
            else
            begin
                if (e < 0)
                begin
                    e = victim_slot();
                    slot_ip[e] = it.addr_ip;
                end
                slot_state[e] = ST_PENDING;
                slot_stamp[e] = it.now_ticks;
                r.status = RES_REQUEST;
                r.dest_mac = MAC_BCAST;
                r.peer_target_ip = it.addr_ip;
            end
        end
        else if (it.frame_len < MIN_FRAME_LEN || it.hw_type != 16'd1
                 || it.proto_type != 16'h0800 || it.hw_addr_len != 8'd6
                 || it.proto_addr_len != 8'd4)
            r.status = RES_DROP;
        else
        begin
            to_us = (it.target_ip == my_ip);
            if (it.addr_ip != 32'd0)
            begin
                e = find_slot(it.addr_ip);
                if (e < 0 && to_us)
                begin
                    e = victim_slot();
                    slot_ip[e] = it.addr_ip;
                end
                if (e >= 0)
                begin
                    slot_mac[e] = it.sender_mac;
                    slot_stamp[e] = it.now_ticks;
                    slot_state[e] = ST_VALID;
                end
            end
            if (it.opcode != 16'd1 || !to_us)
                r.status = RES_ACCEPT;
            else
            begin
                r.status = RES_REPLY;
                r.dest_mac = it.eth_source_mac;
                r.peer_target_mac = it.sender_mac;
                r.peer_target_ip = it.addr_ip;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t   it;
        result_t exp_r;
        result_t got;
        if (!rst_n)
        begin
            my_ip = '0;
            my_mac = '0;
            valid_lim = 31'd60000;
            retry_lim = 31'd1000;
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                slot_ip[i] = '0;
                slot_mac[i] = '0;
                slot_state[i] = ST_FREE;
                slot_stamp[i] = '0;
            end
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_OWN_IP:      my_ip = cfg_data[31:0];
                    CFG_OWN_MAC:     my_mac = cfg_data;
                    CFG_VALID_TICKS: valid_lim = cfg_data[30:0];
                    CFG_RETRY_TICKS: retry_lim = cfg_data[30:0];
                    default: ;
                endcase
            if (m_tvalid && m_tready)
            begin
                got.status = m_tdata[2:0];
                got.resolved_mac = m_tdata[50:3];
                got.dest_mac = m_tdata[98:51];
                got.peer_target_mac = m_tdata[146:99];
                got.peer_target_ip = m_tdata[178:147];
                if (expected_results.size() == 0)
                begin
                    $error("result item with nothing expected: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got.status != exp_r.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.status, got.status);
                        fail_count++;
                    end
                    if (got.resolved_mac != exp_r.resolved_mac)
                    begin
                        $error("resolved_mac: expected %h, got %h",
                               exp_r.resolved_mac, got.resolved_mac);
                        fail_count++;
                    end
                    if (got.dest_mac != exp_r.dest_mac)
                    begin
                        $error("dest_mac: expected %h, got %h", exp_r.dest_mac, got.dest_mac);
                        fail_count++;
                    end
                    if (got.peer_target_mac != exp_r.peer_target_mac)
                    begin
                        $error("peer_target_mac: expected %h, got %h",
                               exp_r.peer_target_mac, got.peer_target_mac);
                        fail_count++;
                    end
                    if (got.peer_target_ip != exp_r.peer_target_ip)
                    begin
                        $error("peer_target_ip: expected %h, got %h",
                               exp_r.peer_target_ip, got.peer_target_ip);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                it.req_type = s_tuser;
                it.now_ticks = s_tdata[31:0];
                it.addr_ip = s_tdata[63:32];
                it.sender_mac = s_tdata[111:64];
                it.target_ip = s_tdata[143:112];
                it.eth_source_mac = s_tdata[191:144];
                it.opcode = s_tdata[207:192];
                it.frame_len = s_tdata[218:208];
                it.hw_type = s_tdata[234:219];
                it.proto_type = s_tdata[250:235];
                it.hw_addr_len = s_tdata[258:251];
                it.proto_addr_len = s_tdata[266:259];
                resolve_item(it, exp_r);
                expected_results.push_back(exp_r);
            end
        end
    end
endmodule

@@ verif/arp_cache_resolver_core_tb.sv @@
// Testbench top for the ARP cache resolver: clock, reset, config writes, directed and
// random lookup/frame items under several idle patterns, and the verdict.
// Depends on arpc_pkg, arp_cache_resolver_core, arp_cache_resolver_core_checker.
`timescale 1ns / 1ps
module arp_cache_resolver_core_tb;
    import arpc_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [271:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [183:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [47:0]  cfg_data;

    int fail_count;
    int results_owed;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    bit hold_ack;
    longint cycles;

    logic [31:0] host_ip;
    logic [31:0] tick;
    logic [31:0] tick_scale;
    logic [30:0] cur_valid;
    logic [31:0] ip_pool [12];

    arp_cache_resolver_core DUT (.*);

    arp_cache_resolver_core_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 1000000)
            begin
                $display("arp_cache_resolver_core: mismatch");
                $finish;
            end
        end
    end

    // result side: random stalls plus an occasional long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        hold_ack = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack = hold_req;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [271:0] pack_item(item_t it);
        return {5'b0, it.proto_addr_len, it.hw_addr_len, it.proto_type, it.hw_type,
                it.frame_len, it.opcode, it.eth_source_mac, it.target_ip,
                it.sender_mac, it.addr_ip, it.now_ticks};
    endfunction

    function automatic logic [47:0] rand_mac();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic item_t good_frame(logic [31:0] now, logic [31:0] ip,
                                         logic [31:0] target, logic [15:0] op);
        item_t it;
        it = '0;
        it.req_type = 1'b1;
        it.now_ticks = now;
        it.addr_ip = ip;
        it.sender_mac = rand_mac();
        it.target_ip = target;
        it.eth_source_mac = rand_mac();
        it.opcode = op;
        it.frame_len = 11'($urandom_range(42, 2047));
        it.hw_type = 16'd1;
        it.proto_type = 16'h0800;
        it.hw_addr_len = 8'd6;
        it.proto_addr_len = 8'd4;
        return it;
    endfunction

    function automatic item_t lookup_item(logic [31:0] now, logic [31:0] ip);
        item_t it;
        it = '0;
        it.now_ticks = now;
        it.addr_ip = ip;
        return it;
    endfunction

    task automatic send_item(input item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_item(it);
        s_tuser <= it.req_type;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    task automatic drain();
        wait_results();
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] ip, input logic [30:0] vt,
                              input logic [30:0] rt);
        host_ip = ip;
        cur_valid = vt;
        write_reg(CFG_OWN_IP, {16'd0, ip});
        write_reg(CFG_OWN_MAC, rand_mac());
        write_reg(CFG_VALID_TICKS, {17'd0, vt});
        write_reg(CFG_RETRY_TICKS, {17'd0, rt});
        @(posedge clk);
    endtask

    function automatic logic [31:0] next_tick();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            tick = tick + $urandom_range(0, 2 * tick_scale);
        else if (r < 80)
            tick = tick + cur_valid + $urandom_range(0, tick_scale);
        else if (r < 88)
            tick = tick - $urandom_range(0, tick_scale);
        else
            tick = $urandom();
        return tick;
    endfunction

    function automatic item_t random_item();
        item_t it;
        int r;
        logic [31:0] ip;
        logic [31:0] tgt;
        r = $urandom_range(99);
        ip = ($urandom_range(99) < 4) ? 32'd0 : ip_pool[4'($urandom_range(11))];
        tgt = ($urandom_range(1)) ? host_ip : ip_pool[4'($urandom_range(11))];
        if (r < 45)
            it = lookup_item(next_tick(), ip);
        else if (r < 85)
            it = good_frame(next_tick(), ip, tgt,
                            ($urandom_range(9) == 0) ? 16'($urandom()) :
                            16'($urandom_range(1, 2)));
        else if (r < 92)
        begin
            it = good_frame(next_tick(), ip, tgt, 16'd1);
            case ($urandom_range(4))
                0: it.frame_len = 11'($urandom_range(0, 41));
                1: it.hw_type = 16'($urandom());
                2: it.proto_type = 16'($urandom());
                3: it.hw_addr_len = 8'($urandom());
                default: it.proto_addr_len = 8'($urandom());
            endcase
        end
        else
        begin
            it.req_type = 1'($urandom_range(1));
            it.now_ticks = next_tick();
            it.addr_ip = $urandom();
            it.sender_mac = rand_mac();
            it.target_ip = $urandom_range(1) ? host_ip : $urandom();
            it.eth_source_mac = rand_mac();
            it.opcode = 16'($urandom());
            it.frame_len = 11'($urandom_range(0, 2047));
            it.hw_type = 16'($urandom());
            it.proto_type = 16'($urandom());
            it.hw_addr_len = 8'($urandom());
            it.proto_addr_len = 8'($urandom());
        end
        return it;
    endfunction

    initial
    begin
        item_t it;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        tick = 32'd100;
        tick_scale = 32'd1000;
        for (int i = 0; i < 12; i++)
            ip_pool[i] = $urandom();
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(32'hC0A8_0001, 31'd60000, 31'd1000);
        // miss, wait, retry, learn, hit, stale
        send_item(lookup_item(32'd100, ip_pool[0]));
        send_item(lookup_item(32'd110, ip_pool[0]));
        send_item(lookup_item(32'd1200, ip_pool[0]));
        send_item(good_frame(32'd1300, ip_pool[0], host_ip, 16'd2));
        send_item(lookup_item(32'd1400, ip_pool[0]));
        send_item(lookup_item(32'd70000, ip_pool[0]));
        // request for us from a new sender, frame for someone else and a lookup of its sender, zero sender
        send_item(good_frame(32'd70100, ip_pool[1], host_ip, 16'd1));
        send_item(good_frame(32'd70200, ip_pool[2], ip_pool[3], 16'd1));
        send_item(lookup_item(32'd70300, ip_pool[2]));
        send_item(good_frame(32'd70400, 32'd0, host_ip, 16'd1));
        // malformed frames, one field each
        for (int k = 0; k < 5; k++)
        begin
            it = good_frame(32'd70500, ip_pool[4], host_ip, 16'd1);
            case (k)
                0: it.frame_len = 11'd41;
                1: it.hw_type = 16'd2;
                2: it.proto_type = 16'h86DD;
                3: it.hw_addr_len = 8'd5;
                default: it.proto_addr_len = 8'd5;
            endcase
            send_item(it);
        end
        it = good_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        it.sender_mac = '1;
        it.eth_source_mac = '1;
        it.frame_len = 11'd2047;
        send_item(it);
        send_item(lookup_item(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(lookup_item(32'd0, 32'd0));
        // overfill the cache to force evictions
        for (int k = 0; k < 10; k++)
            send_item(lookup_item(32'(80000 + k * 5), ip_pool[4'(k % 12)] ^ 32'h5A5A_0000));
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0; recv_stall_pct = 0;
                    set_config($urandom(), 31'd60000, 31'd1000);
                    tick_scale = 32'd1000;
                end
                1:
                begin
                    send_idle_pct = 61; recv_stall_pct = 0;
                    set_config(32'd0, 31'd1, 31'd1);
                    tick_scale = 32'd2;
                end
                2:
                begin
                    send_idle_pct = 0; recv_stall_pct = 61;
                    set_config(32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
                    tick_scale = 32'h0010_0000;
                end
                default:
                begin
                    send_idle_pct = 37; recv_stall_pct = 37;
                    set_config($urandom(), 31'd20000, 31'($urandom_range(100, 5000)));
                    tick_scale = 32'd2000;
                end
            endcase
            ip_pool[4'($urandom_range(11))] = host_ip;
            for (int n = 0; n < 207; n++)
            begin
                if (n == 60)
                    hold_req = ~hold_req;
                if (n == 140)
                    wait_results();
                send_item(random_item());
            end
            drain();
        end

        if (fail_count == 0)
            $display("arp_cache_resolver_core: match");
        else
            $display("arp_cache_resolver_core: mismatch");
        $finish;
    end
endmodule
